// ===== rtl/spp_pkg.sv =====
`timescale 1ns / 1ps

package spp_pkg;

	// Default sizing of the lattice and the random draws.
	localparam int MAX_SITES_DEF = 1024;
	localparam int DRAW_BITS_DEF = 16;

	// Population sums saturate at all ones.
	localparam int SUM_W = 48;

	// Operation code carried in the input tuser.
	localparam int OP_W = 2;

	// Register reset values: rates as fractions of 2^RST_SCALE_BITS, ring length in sites.
	localparam int RST_SCALE_BITS = 16;
	localparam int ALPHA_RST = 14418;
	localparam int BETA_RST = 6554;
	localparam int GAMMA_RST = 58982;
	localparam int RING_RST = 1000;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_UPDATE = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_CLEAR  = 2'd3
	} spp_op_t;

	typedef enum logic [1:0] {
		REG_ALPHA = 2'd0,
		REG_BETA  = 2'd1,
		REG_GAMMA = 2'd2,
		REG_RING  = 2'd3
	} spp_reg_t;

	// Outcome of the draw compares for one update attempt.
	typedef struct packed {
		logic heads;
		logic a1;
		logic b1;
		logic a2;
		logic b2;
		logic g2;
	} spp_flags_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] code;
	} spp_rw_t;

	// Site writes requested by the update stage; bits are {a, b}.
	typedef struct packed {
		logic       we_i;
		logic       we_j;
		logic [1:0] bits_i;
		logic [1:0] bits_j;
		logic       changed;
	} spp_wr_t;

	// Pair rewrite table; code order is {a_i, a_j, b_i, b_j}.
	function automatic spp_rw_t rewrite(input logic [3:0] k, input spp_flags_t f);
		spp_rw_t r;
		r.hit = 1'b0;
		r.code = k;
		case (k) inside
			4'd1, 4'd4: begin
				r.hit = f.a1;
				r.code = 4'd8;
			end
			4'd2: begin
				r.hit = f.a1;
				r.code = 4'd1;
			end
			4'd5: begin
				r.hit = f.a1;
				r.code = 4'd10;
			end
			4'd13: begin
				r.hit = f.a1;
				r.code = 4'd14;
			end
			4'd3: begin
				r.hit = f.b1;
				r.code = 4'd0;
			end
			4'd7: begin
				r.hit = f.b1;
				r.code = 4'd8;
			end
			4'd15: begin
				r.hit = f.b1;
				r.code = 4'd12;
			end
			4'd8: begin
				r.hit = f.heads ? f.a2 : 1'b1;
				r.code = f.heads ? 4'd12 : 4'd4;
			end
			4'd9: begin
				r.hit = f.heads ? f.a2 : 1'b1;
				r.code = f.heads ? 4'd14 : 4'd6;
			end
			4'd10: begin
				r.hit = f.heads ? f.a2 : 1'b1;
				r.code = f.heads ? 4'd13 : 4'd5;
			end
			4'd6: begin
				r.hit = f.heads ? f.g2 : 1'b1;
				r.code = f.heads ? 4'd3 : 4'd9;
			end
			4'd14: begin
				r.hit = f.heads ? f.g2 : 1'b1;
				r.code = f.heads ? 4'd11 : 4'd13;
			end
			4'd11: begin
				r.hit = f.heads ? f.a2 : f.b2;
				r.code = f.heads ? 4'd15 : 4'd4;
			end
			default: begin
				r.hit = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/spp_bank.sv =====
`timescale 1ns / 1ps

// One bank of site bits: one write port, one registered read port.
module spp_bank #(
	parameter int ROWS  = 512,
	parameter int ROW_W = 9
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ROW_W-1:0] waddr,
	input  logic [1:0]       wdata,
	input  logic             re,
	input  logic [ROW_W-1:0] raddr,
	output logic [1:0]       rdata
);

	logic [1:0] mem_q [ROWS];
	logic [1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Hold read data until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

// ===== rtl/spp_cfg.sv =====
`timescale 1ns / 1ps

// Rate and ring length registers behind the APB port.
module spp_cfg #(
	parameter int MAX_SITES = spp_pkg::MAX_SITES_DEF,
	parameter int DRAW_BITS = spp_pkg::DRAW_BITS_DEF,
	parameter int RATE_W    = DRAW_BITS + 1,
	parameter int CNT_W     = $clog2(MAX_SITES + 1),
	parameter int DATA_W    = 32,
	parameter int ADDR_LSB  = 2,
	parameter int PADDR_W   = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output logic [RATE_W-1:0]  alpha,
	output logic [RATE_W-1:0]  beta,
	output logic [RATE_W-1:0]  gamma,
	output logic [CNT_W-1:0]   ring_len
);

	localparam logic [RATE_W-1:0] ALPHA_INIT =
		RATE_W'((64'(spp_pkg::ALPHA_RST) << DRAW_BITS) >> spp_pkg::RST_SCALE_BITS);
	localparam logic [RATE_W-1:0] BETA_INIT =
		RATE_W'((64'(spp_pkg::BETA_RST) << DRAW_BITS) >> spp_pkg::RST_SCALE_BITS);
	localparam logic [RATE_W-1:0] GAMMA_INIT =
		RATE_W'((64'(spp_pkg::GAMMA_RST) << DRAW_BITS) >> spp_pkg::RST_SCALE_BITS);
	localparam logic [CNT_W-1:0] RING_INIT =
		CNT_W'((MAX_SITES < spp_pkg::RING_RST) ? MAX_SITES : spp_pkg::RING_RST);

	logic [RATE_W-1:0] alpha_q;
	logic [RATE_W-1:0] beta_q;
	logic [RATE_W-1:0] gamma_q;
	logic [CNT_W-1:0]  ring_q;
	logic              wr_en;
	spp_pkg::spp_reg_t idx;

	assign wr_en  = psel & penable & pwrite;
	assign idx    = spp_pkg::spp_reg_t'(paddr[ADDR_LSB +: 2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_INIT;
			beta_q  <= BETA_INIT;
			gamma_q <= GAMMA_INIT;
			ring_q  <= RING_INIT;
		end else if (wr_en) begin
			unique case (idx)
				spp_pkg::REG_ALPHA: alpha_q <= pwdata[RATE_W-1:0];
				spp_pkg::REG_BETA:  beta_q  <= pwdata[RATE_W-1:0];
				spp_pkg::REG_GAMMA: gamma_q <= pwdata[RATE_W-1:0];
				spp_pkg::REG_RING:  ring_q  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			spp_pkg::REG_ALPHA: prdata = DATA_W'(alpha_q);
			spp_pkg::REG_BETA:  prdata = DATA_W'(beta_q);
			spp_pkg::REG_GAMMA: prdata = DATA_W'(gamma_q);
			spp_pkg::REG_RING:  prdata = DATA_W'(ring_q);
			default:            prdata = '0;
		endcase
	end

	assign alpha    = alpha_q;
	assign beta     = beta_q;
	assign gamma    = gamma_q;
	assign ring_len = ring_q;

endmodule

// ===== rtl/spp_update.sv =====
`timescale 1ns / 1ps

// Rewrite decision, site writes and next counts and sums for one item.
module spp_update #(
	parameter int DRAW_BITS = spp_pkg::DRAW_BITS_DEF,
	parameter int RATE_W    = DRAW_BITS + 1,
	parameter int CNT_W     = 11
) (
	input  spp_pkg::spp_op_t            op,
	input  logic                        bad,
	input  logic                        wa,
	input  logic                        wb,
	input  logic [1:0]                  old_i,
	input  logic [1:0]                  old_j,
	input  logic [DRAW_BITS-1:0]        d1,
	input  logic [DRAW_BITS-1:0]        d2,
	input  logic [RATE_W-1:0]           alpha,
	input  logic [RATE_W-1:0]           beta,
	input  logic [RATE_W-1:0]           gamma,
	input  logic [CNT_W-1:0]            cnt_a,
	input  logic [CNT_W-1:0]            cnt_b,
	input  logic [spp_pkg::SUM_W-1:0]   sum_a,
	input  logic [spp_pkg::SUM_W-1:0]   sum_b,
	output spp_pkg::spp_wr_t            wr,
	output logic [CNT_W-1:0]            cnt_a_nxt,
	output logic [CNT_W-1:0]            cnt_b_nxt,
	output logic [spp_pkg::SUM_W-1:0]   sum_a_nxt,
	output logic [spp_pkg::SUM_W-1:0]   sum_b_nxt
);

	localparam int SUM_X = spp_pkg::SUM_W + 1;

	spp_pkg::spp_flags_t flags;
	spp_pkg::spp_rw_t    rw;
	logic [3:0]          k;
	logic [SUM_X-1:0]    add_a;
	logic [SUM_X-1:0]    add_b;
	logic [1:0]          new_i;
	logic [1:0]          new_j;

	assign k = {old_i[1], old_j[1], old_i[0], old_j[0]};

	assign flags.heads = ~d1[DRAW_BITS-1];
	assign flags.a1    = RATE_W'(d1) < alpha;
	assign flags.b1    = RATE_W'(d1) < beta;
	assign flags.a2    = RATE_W'(d2) < alpha;
	assign flags.b2    = RATE_W'(d2) < beta;
	assign flags.g2    = RATE_W'(d2) < gamma;

	assign rw = spp_pkg::rewrite(k, flags);

	// Saturating sums of the live counts.
	assign add_a = {1'b0, sum_a} + SUM_X'(cnt_a);
	assign add_b = {1'b0, sum_b} + SUM_X'(cnt_b);

	always_comb begin
		wr        = '0;
		sum_a_nxt = sum_a;
		sum_b_nxt = sum_b;
		if (!bad) begin
			unique case (op)
				spp_pkg::OP_WRITE: begin
					wr.we_i   = 1'b1;
					wr.bits_i = {wa, wb};
				end
				spp_pkg::OP_UPDATE: begin
					if (rw.hit) begin
						wr.we_i    = 1'b1;
						wr.we_j    = 1'b1;
						wr.bits_i  = {rw.code[3], rw.code[1]};
						wr.bits_j  = {rw.code[2], rw.code[0]};
						wr.changed = 1'b1;
					end
				end
				spp_pkg::OP_SAMPLE: begin
					sum_a_nxt = add_a[SUM_X-1] ? '1 : add_a[spp_pkg::SUM_W-1:0];
					sum_b_nxt = add_b[SUM_X-1] ? '1 : add_b[spp_pkg::SUM_W-1:0];
				end
				spp_pkg::OP_CLEAR: begin
					sum_a_nxt = '0;
					sum_b_nxt = '0;
				end
				default: ;
			endcase
		end
	end

	// Swap the old contribution of each written site for the new one.
	assign new_i = wr.we_i ? wr.bits_i : old_i;
	assign new_j = wr.we_j ? wr.bits_j : old_j;

	assign cnt_a_nxt = cnt_a + CNT_W'(new_i[1]) + CNT_W'(new_j[1])
		- CNT_W'(old_i[1]) - CNT_W'(old_j[1]);
	assign cnt_b_nxt = cnt_b + CNT_W'(new_i[0]) + CNT_W'(new_j[0])
		- CNT_W'(old_i[0]) - CNT_W'(old_j[0]);

endmodule

// ===== rtl/stochastic_prey_predator_lattice_update.sv =====
`timescale 1ns / 1ps

// Each result passes the stage 1 register and then the output register to m_tvalid.
// Throughput: one item per cycle while the output is not stalled; the store is read at
// the input transfer and written as the item leaves stage 1, with a forwarding path
// between them. Reset: asynchronous; rates and ring length load their defaults, counts
// and sums clear, and a clearing pass zeroes the site store before inputs are taken.
module stochastic_prey_predator_lattice_update #(
	parameter int MAX_SITES = spp_pkg::MAX_SITES_DEF,
	parameter int DRAW_BITS = spp_pkg::DRAW_BITS_DEF,
	localparam int SITE_W   = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1,
	localparam int CNT_W    = $clog2(MAX_SITES + 1),
	localparam int RATE_W   = DRAW_BITS + 1,
	localparam int IN_BITS  = SITE_W + 2 + 2 * DRAW_BITS,
	localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 2 * CNT_W + 2 * spp_pkg::SUM_W,
	localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8,
	localparam int DATA_W   = (RATE_W > 32) ? 64 : 32,
	localparam int ADDR_LSB = (RATE_W > 32) ? 3 : 2,
	localparam int PADDR_W  = ADDR_LSB + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// site, write_a, write_b, coin_draw, rate_draw (from bit 0 up), zero pad
	input  logic [IN_DW-1:0]             s_tdata,
	// op
	input  logic [spp_pkg::OP_W-1:0]     s_tuser,
	// Result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// count_a, count_b, sum_a, sum_b (from bit 0 up), zero pad
	output logic [OUT_DW-1:0]            m_tdata,
	// changed, bad_site
	output logic [1:0]                   m_tuser,
	// Configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [PADDR_W-1:0]           paddr,
	input  logic [DATA_W-1:0]            pwdata,
	output logic [DATA_W-1:0]            prdata,
	output logic                         pready
);

	// Site 0 lives in a flop; even sites 2,4,.. in one bank, odd sites in the
	// other. A site and its clockwise neighbour then never share a bank, even
	// across the wrap, so each bank sees at most one write per item.
	localparam int ROWS  = (MAX_SITES + 1) / 2;
	localparam int ROW_W = (SITE_W > 1) ? SITE_W - 1 : 1;

	// ---------------------------------------------------------------- config
	logic [RATE_W-1:0] alpha;
	logic [RATE_W-1:0] beta;
	logic [RATE_W-1:0] gamma;
	logic [CNT_W-1:0]  ring_len;
	logic [CNT_W-1:0]  eff_len;

	spp_cfg #(
		.MAX_SITES(MAX_SITES),
		.DRAW_BITS(DRAW_BITS),
		.RATE_W   (RATE_W),
		.CNT_W    (CNT_W),
		.DATA_W   (DATA_W),
		.ADDR_LSB (ADDR_LSB),
		.PADDR_W  (PADDR_W)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.alpha   (alpha),
		.beta    (beta),
		.gamma   (gamma),
		.ring_len(ring_len)
	);

	// Clamp the ring length to 2..MAX_SITES.
	assign eff_len = (ring_len < CNT_W'(2)) ? CNT_W'(2) :
		(ring_len > CNT_W'(MAX_SITES)) ? CNT_W'(MAX_SITES) : ring_len;

	// ---------------------------------------------------------------- control
	logic             clearing_q;
	logic [ROW_W-1:0] clr_q;
	logic             s1_valid_q;
	logic             out_valid_q;
	logic             advance;
	logic             s1_go;
	logic             accept;

	// The output register frees when empty or when its transfer completes.
	assign advance  = ~out_valid_q | m_tready;
	assign s1_go    = s1_valid_q & advance;
	assign s_tready = ~clearing_q & (~s1_valid_q | advance);
	assign accept   = s_tvalid & s_tready;

	// Sweep both banks to zero after reset; hold off input transfers meanwhile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + ROW_W'(1);
			if (clr_q == ROW_W'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// ---------------------------------------------------------------- input side
	spp_pkg::spp_op_t      op_in;
	logic [SITE_W-1:0]     site_in;
	logic [SITE_W-1:0]     j_in;
	logic [CNT_W-1:0]      site_ext;
	logic [CNT_W-1:0]      site_plus;
	logic                  bad_in;

	assign op_in     = spp_pkg::spp_op_t'(s_tuser);
	assign site_in   = s_tdata[SITE_W-1:0];
	assign site_ext  = CNT_W'(site_in);
	assign site_plus = site_ext + CNT_W'(1);
	// Neighbour wraps to site zero past the last site in use.
	assign j_in      = (site_plus == eff_len) ? '0 : SITE_W'(site_plus);
	assign bad_in    = ((op_in == spp_pkg::OP_WRITE) || (op_in == spp_pkg::OP_UPDATE))
		&& (site_ext >= eff_len);

	// ---------------------------------------------------------------- stage 1
	spp_pkg::spp_op_t      op_s1;
	logic [SITE_W-1:0]     site_s1;
	logic [SITE_W-1:0]     j_s1;
	logic                  wa_s1;
	logic                  wb_s1;
	logic [DRAW_BITS-1:0]  d1_s1;
	logic [DRAW_BITS-1:0]  d2_s1;
	logic                  bad_s1;
	logic                  fwd_i_s1;
	logic                  fwd_j_s1;
	logic [1:0]            fwd_i_bits_s1;
	logic [1:0]            fwd_j_bits_s1;

	spp_pkg::spp_wr_t      wr;
	logic [1:0]            site0_q;
	logic [1:0]            even_rd;
	logic [1:0]            odd_rd;
	logic [1:0]            old_i;
	logic [1:0]            old_j;
	logic [CNT_W-1:0]      cnt_a_q;
	logic [CNT_W-1:0]      cnt_b_q;
	logic [spp_pkg::SUM_W-1:0] sum_a_q;
	logic [spp_pkg::SUM_W-1:0] sum_b_q;
	logic [CNT_W-1:0]      cnt_a_nxt;
	logic [CNT_W-1:0]      cnt_b_nxt;
	logic [spp_pkg::SUM_W-1:0] sum_a_nxt;
	logic [spp_pkg::SUM_W-1:0] sum_b_nxt;

	// The item leaving stage 1 writes the store at the same edge that reads
	// for the incoming one, so capture its written values for the newcomer.
	logic hit_ii;
	logic hit_ji;
	logic hit_ij;
	logic hit_jj;

	assign hit_ii = wr.we_i && (site_s1 == site_in);
	assign hit_ji = wr.we_j && (j_s1 == site_in);
	assign hit_ij = wr.we_i && (site_s1 == j_in);
	assign hit_jj = wr.we_j && (j_s1 == j_in);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1         <= op_in;
			site_s1       <= site_in;
			j_s1          <= j_in;
			wa_s1         <= s_tdata[SITE_W];
			wb_s1         <= s_tdata[SITE_W+1];
			d1_s1         <= s_tdata[SITE_W+2 +: DRAW_BITS];
			d2_s1         <= s_tdata[SITE_W+2+DRAW_BITS +: DRAW_BITS];
			bad_s1        <= bad_in;
			fwd_i_s1      <= s1_valid_q && (hit_ii || hit_ji);
			fwd_j_s1      <= s1_valid_q && (hit_ij || hit_jj);
			fwd_i_bits_s1 <= hit_ii ? wr.bits_i : wr.bits_j;
			fwd_j_bits_s1 <= hit_ij ? wr.bits_i : wr.bits_j;
		end
	end

	// Pick each site's bits: the site 0 flop, a forwarded write, or a bank.
	assign old_i = (site_s1 == '0) ? site0_q :
		fwd_i_s1 ? fwd_i_bits_s1 : (site_s1[0] ? odd_rd : even_rd);
	assign old_j = (j_s1 == '0) ? site0_q :
		fwd_j_s1 ? fwd_j_bits_s1 : (j_s1[0] ? odd_rd : even_rd);

	spp_update #(
		.DRAW_BITS(DRAW_BITS),
		.RATE_W   (RATE_W),
		.CNT_W    (CNT_W)
	) u_update (
		.op       (op_s1),
		.bad      (bad_s1),
		.wa       (wa_s1),
		.wb       (wb_s1),
		.old_i    (old_i),
		.old_j    (old_j),
		.d1       (d1_s1),
		.d2       (d2_s1),
		.alpha    (alpha),
		.beta     (beta),
		.gamma    (gamma),
		.cnt_a    (cnt_a_q),
		.cnt_b    (cnt_b_q),
		.sum_a    (sum_a_q),
		.sum_b    (sum_b_q),
		.wr       (wr),
		.cnt_a_nxt(cnt_a_nxt),
		.cnt_b_nxt(cnt_b_nxt),
		.sum_a_nxt(sum_a_nxt),
		.sum_b_nxt(sum_b_nxt)
	);

	// ---------------------------------------------------------------- site store
	logic             ev_we_i;
	logic             ev_we_j;
	logic             od_we_i;
	logic             od_we_j;
	logic             ev_we;
	logic             od_we;
	logic [ROW_W-1:0] ev_waddr;
	logic [ROW_W-1:0] od_waddr;
	logic [1:0]       ev_wdata;
	logic [1:0]       od_wdata;
	logic [ROW_W-1:0] ev_raddr;
	logic [ROW_W-1:0] od_raddr;

	assign ev_we_i = wr.we_i && !site_s1[0] && (site_s1 != '0);
	assign ev_we_j = wr.we_j && !j_s1[0] && (j_s1 != '0);
	assign od_we_i = wr.we_i && site_s1[0];
	assign od_we_j = wr.we_j && j_s1[0];

	assign ev_we    = clearing_q | (s1_go & (ev_we_i | ev_we_j));
	assign od_we    = clearing_q | (s1_go & (od_we_i | od_we_j));
	assign ev_waddr = clearing_q ? clr_q :
		ROW_W'((ev_we_i ? site_s1 : j_s1) >> 1);
	assign od_waddr = clearing_q ? clr_q :
		ROW_W'((od_we_i ? site_s1 : j_s1) >> 1);
	assign ev_wdata = clearing_q ? 2'b00 : (ev_we_i ? wr.bits_i : wr.bits_j);
	assign od_wdata = clearing_q ? 2'b00 : (od_we_i ? wr.bits_i : wr.bits_j);

	// Read both banks at the input transfer: one of site and neighbour is odd, or the neighbour is site 0.
	assign ev_raddr = ROW_W'((site_in[0] ? j_in : site_in) >> 1);
	assign od_raddr = ROW_W'((site_in[0] ? site_in : j_in) >> 1);

	spp_bank #(
		.ROWS (ROWS),
		.ROW_W(ROW_W)
	) u_even (
		.clk  (clk),
		.we   (ev_we),
		.waddr(ev_waddr),
		.wdata(ev_wdata),
		.re   (accept),
		.raddr(ev_raddr),
		.rdata(even_rd)
	);

	spp_bank #(
		.ROWS (ROWS),
		.ROW_W(ROW_W)
	) u_odd (
		.clk  (clk),
		.we   (od_we),
		.waddr(od_waddr),
		.wdata(od_wdata),
		.re   (accept),
		.raddr(od_raddr),
		.rdata(odd_rd)
	);

	// ---------------------------------------------------------------- state and result
	logic [OUT_DW-1:0] out_data_q;
	logic [1:0]        out_user_q;

	// Site 0, live counts and sums advance when stage 1 hands off its item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site0_q <= 2'b00;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (s1_go) begin
			if (wr.we_i && (site_s1 == '0)) begin
				site0_q <= wr.bits_i;
			end else if (wr.we_j && (j_s1 == '0)) begin
				site0_q <= wr.bits_j;
			end
			cnt_a_q <= cnt_a_nxt;
			cnt_b_q <= cnt_b_nxt;
			sum_a_q <= sum_a_nxt;
			sum_b_q <= sum_b_nxt;
		end
	end

	// Output register: load when it frees, hold while the transfer stalls.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_data_q <= OUT_DW'({sum_b_nxt, sum_a_nxt, cnt_b_nxt, cnt_a_nxt});
			out_user_q <= {bad_s1, wr.changed};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
